### rtl/ctr_pkg.sv
// ----------------------------------------------------------------------------
// ctr_pkg
// Shared constants, codes and types of the console terminal register block.
// ----------------------------------------------------------------------------
package ctr_pkg;

    // typeahead queue geometry
    localparam int TYPEAHEAD_DEPTH = 256;
    localparam int PTR_W           = $clog2(TYPEAHEAD_DEPTH);
    localparam int CNT_W           = $clog2(TYPEAHEAD_DEPTH + 1);
    localparam int ENTRY_W         = 9;
    localparam int BRK_BIT         = 8;

    // item field widths
    localparam int MODE_W = 4;
    localparam int WORD_W = 16;
    localparam int CHAR_W = 8;
    localparam int CFG_IDX_W = 2;

    // item operation codes
    localparam logic [MODE_W-1:0] MODE_RXCS_RD  = 4'd0;
    localparam logic [MODE_W-1:0] MODE_RXDB_RD  = 4'd1;
    localparam logic [MODE_W-1:0] MODE_TXCS_RD  = 4'd2;
    localparam logic [MODE_W-1:0] MODE_RXCS_WR  = 4'd3;
    localparam logic [MODE_W-1:0] MODE_TXCS_WR  = 4'd4;
    localparam logic [MODE_W-1:0] MODE_TXDB_WR  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_HOST_CH  = 4'd6;
    localparam logic [MODE_W-1:0] MODE_POLL     = 4'd7;
    localparam logic [MODE_W-1:0] MODE_TX_DONE  = 4'd8;
    localparam logic [MODE_W-1:0] MODE_TA_CLEAR = 4'd9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RX_SEVEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_SEVEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALT_EN  = 2'd2;

    // register bits
    localparam logic [WORD_W-1:0] CS_DONE   = 16'h0080;
    localparam logic [WORD_W-1:0] CS_IE     = 16'h0040;
    localparam int                CS_IE_BIT = 6;
    localparam logic [WORD_W-1:0] RB_ERR    = 16'h8000;
    localparam logic [WORD_W-1:0] RB_FRM    = 16'h2000;
    localparam logic [WORD_W-1:0] RB_BRK    = 16'h0400;
    localparam logic [CHAR_W-1:0] CHAR8     = 8'hFF;
    localparam logic [CHAR_W-1:0] CHAR7     = 8'h7F;

    // typeahead control and status
    typedef struct packed {
        logic               rd_req;   // read head entry (data next cycle)
        logic               put;
        logic               get;
        logic               clear;
        logic [ENTRY_W-1:0] put_data;
    } t_ta_cmd;

    typedef struct packed {
        logic               empty;
        logic               full;
        logic [ENTRY_W-1:0] rd_data;
    } t_ta_stat;

endpackage

### rtl/ctr_if.sv
// ----------------------------------------------------------------------------
// ctr_if
// Handshake channels of the console terminal register block.
// ----------------------------------------------------------------------------
interface ctr_in_if import ctr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [WORD_W-1:0] write_data;
    logic [CHAR_W-1:0] host_char;
    logic              host_break;

    modport source (output valid, mode, write_data, host_char, host_break, input ready);
    modport sink   (input valid, mode, write_data, host_char, host_break, output ready);
endinterface

interface ctr_out_if import ctr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] read_data;
    logic              rx_interrupt;
    logic              tx_interrupt;
    logic              typeahead_accepted;
    logic              tx_char_valid;
    logic [CHAR_W-1:0] tx_char;
    logic              halt_request;

    modport source (output valid, read_data, rx_interrupt, tx_interrupt,
                    typeahead_accepted, tx_char_valid, tx_char, halt_request,
                    input ready);
    modport sink   (input valid, read_data, rx_interrupt, tx_interrupt,
                    typeahead_accepted, tx_char_valid, tx_char, halt_request,
                    output ready);
endinterface

interface ctr_cfg_if import ctr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic                 data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/console_terminal_registers_unit.sv
// ----------------------------------------------------------------------------
// console_terminal_registers_unit
// Console terminal receive/transmit CSRs with a typeahead queue.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : one beat per operation (register read/write, host char, poll,
//           tx done, typeahead clear). i_in.ready is high while no beat is
//           being processed.
//   o_out : exactly one result beat per input beat, in order.
//   i_cfg : writes rx_seven_bit (0), tx_seven_bit (1), halt_enable (2);
//           always ready, other indexes are dropped. Write only when idle.
// Operation:
//   Accepting a beat also reads the queue head from the typeahead memory;
//   the execute step then applies the update and loads the output
//   register. A new beat is taken only once the execute step is done, as
//   the execute step uses the registered read of the typeahead memory.
//   o_out.valid is registered and rises after the execute step.
// Stall: while o_out holds an untaken beat, one more input beat is taken
//   and waits in the execute step until the output register frees.
// Reset: synchronous, active low; CSRs, queue pointers and config clear,
//   tx done sets. Queue memory contents are not cleared.
// ----------------------------------------------------------------------------
module console_terminal_registers_unit import ctr_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ctr_in_if.sink        i_in,
    ctr_out_if.source     o_out,
    ctr_cfg_if.sink       i_cfg
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state, n_state;

    // captured item
    logic [MODE_W-1:0] r_mode;
    logic [WORD_W-1:0] r_wdata;
    logic [CHAR_W-1:0] r_hchar;
    logic              r_hbrk;

    // config
    logic r_rx_seven, r_tx_seven, r_halt_en;

    // CSR state
    logic              r_rx_done, n_rx_done;
    logic              r_rx_ie, n_rx_ie;
    logic [WORD_W-1:0] r_rx_buf, n_rx_buf;
    logic              r_rx_pend, n_rx_pend;
    logic              r_tx_done, n_tx_done;
    logic              r_tx_ie, n_tx_ie;
    logic [CHAR_W-1:0] r_tx_buf, n_tx_buf;
    logic              r_tx_pend, n_tx_pend;

    // output register
    logic              r_out_valid;
    logic [WORD_W-1:0] r_rd, n_rd;
    logic              r_acc, n_acc;
    logic              r_txv, n_txv;
    logic [CHAR_W-1:0] r_txc, n_txc;
    logic              r_halt, n_halt;

    logic     in_fire, exec_fire, out_free, ie;
    t_ta_cmd  ta_cmd;
    t_ta_stat ta_stat;

    assign in_fire   = i_in.valid && i_in.ready;
    assign out_free  = !r_out_valid || o_out.ready;
    assign exec_fire = (r_state == ST_EXEC) && out_free;
    assign ie        = r_wdata[CS_IE_BIT];

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    ctr_typeahead u_typeahead (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (ta_cmd),
        .o_stat  (ta_stat)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_fire) n_state = ST_EXEC;
            ST_EXEC: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_rx_done = r_rx_done;
        n_rx_ie   = r_rx_ie;
        n_rx_buf  = r_rx_buf;
        n_rx_pend = r_rx_pend;
        n_tx_done = r_tx_done;
        n_tx_ie   = r_tx_ie;
        n_tx_buf  = r_tx_buf;
        n_tx_pend = r_tx_pend;
        n_rd      = '0;
        n_acc     = 1'b0;
        n_txv     = 1'b0;
        n_txc     = '0;
        n_halt    = 1'b0;
        ta_cmd          = '0;
        ta_cmd.rd_req   = in_fire;
        ta_cmd.put_data = {r_hbrk, r_hchar};

        if (exec_fire) begin
            unique case (r_mode)
                MODE_RXCS_RD: begin
                    n_rd = (r_rx_done ? CS_DONE : '0) | (r_rx_ie ? CS_IE : '0);
                end
                MODE_RXDB_RD: begin
                    n_rd      = r_rx_buf;
                    n_rx_done = 1'b0;
                    n_rx_buf  = {8'h00, r_rx_buf[CHAR_W-1:0]};
                    n_rx_pend = 1'b0;
                end
                MODE_TXCS_RD: begin
                    n_rd = (r_tx_done ? CS_DONE : '0) | (r_tx_ie ? CS_IE : '0);
                end
                MODE_RXCS_WR: begin
                    if (!ie) begin
                        n_rx_pend = 1'b0;
                    end else if (r_rx_done && !r_rx_ie) begin
                        n_rx_pend = 1'b1;
                    end
                    n_rx_ie = ie;
                end
                MODE_TXCS_WR: begin
                    if (!ie) begin
                        n_tx_pend = 1'b0;
                    end else if (r_tx_done && !r_tx_ie) begin
                        n_tx_pend = 1'b1;
                    end
                    n_tx_ie = ie;
                end
                MODE_TXDB_WR: begin
                    n_tx_buf  = r_wdata[CHAR_W-1:0];
                    n_tx_done = 1'b0;
                    n_tx_pend = 1'b0;
                end
                MODE_HOST_CH: begin
                    // break with halt enabled flushes the queue before queuing
                    ta_cmd.clear = r_hbrk && r_halt_en;
                    n_acc        = ta_cmd.clear || !ta_stat.full;
                    ta_cmd.put   = n_acc;
                end
                MODE_POLL: begin
                    if (!r_rx_done && !ta_stat.empty) begin
                        ta_cmd.get = 1'b1;
                        if (ta_stat.rd_data[BRK_BIT]) begin
                            n_halt   = r_halt_en;
                            n_rx_buf = RB_ERR | RB_FRM | RB_BRK;
                        end else begin
                            n_rx_buf = {8'h00, ta_stat.rd_data[CHAR_W-1:0]
                                               & (r_rx_seven ? CHAR7 : CHAR8)};
                        end
                        n_rx_done = 1'b1;
                        if (r_rx_ie) begin
                            n_rx_pend = 1'b1;
                        end
                    end
                end
                MODE_TX_DONE: begin
                    if (!r_tx_done) begin
                        n_txv     = 1'b1;
                        n_txc     = r_tx_buf & (r_tx_seven ? CHAR7 : CHAR8);
                        n_tx_done = 1'b1;
                        if (r_tx_ie) begin
                            n_tx_pend = 1'b1;
                        end
                    end
                end
                MODE_TA_CLEAR: begin
                    ta_cmd.clear = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_rx_done   <= 1'b0;
            r_rx_ie     <= 1'b0;
            r_rx_buf    <= '0;
            r_rx_pend   <= 1'b0;
            r_tx_done   <= 1'b1;
            r_tx_ie     <= 1'b0;
            r_tx_buf    <= '0;
            r_tx_pend   <= 1'b0;
            r_rx_seven  <= 1'b0;
            r_tx_seven  <= 1'b0;
            r_halt_en   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rx_done <= n_rx_done;
            r_rx_ie   <= n_rx_ie;
            r_rx_buf  <= n_rx_buf;
            r_rx_pend <= n_rx_pend;
            r_tx_done <= n_tx_done;
            r_tx_ie   <= n_tx_ie;
            r_tx_buf  <= n_tx_buf;
            r_tx_pend <= n_tx_pend;
            if (exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_RX_SEVEN: r_rx_seven <= i_cfg.data;
                    CFG_TX_SEVEN: r_tx_seven <= i_cfg.data;
                    CFG_HALT_EN:  r_halt_en  <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // item capture and result payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mode  <= i_in.mode;
            r_wdata <= i_in.write_data;
            r_hchar <= i_in.host_char;
            r_hbrk  <= i_in.host_break;
        end
        if (exec_fire) begin
            r_rd   <= n_rd;
            r_acc  <= n_acc;
            r_txv  <= n_txv;
            r_txc  <= n_txc;
            r_halt <= n_halt;
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.read_data          = r_rd;
    assign o_out.rx_interrupt       = r_rx_pend;
    assign o_out.tx_interrupt       = r_tx_pend;
    assign o_out.typeahead_accepted = r_acc;
    assign o_out.tx_char_valid      = r_txv;
    assign o_out.tx_char            = r_txc;
    assign o_out.halt_request       = r_halt;

`ifndef SYNTHESIS
    a_rx_pend_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_pend |-> r_rx_ie && r_rx_done)
        else $error("rx interrupt without enable and done");

    a_tx_pend_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_pend |-> r_tx_ie && r_tx_done)
        else $error("tx interrupt without enable and done");

    a_rxdb_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_fire && r_mode == MODE_RXDB_RD |=> !r_rx_done && !r_rx_pend)
        else $error("rxdb read left done or interrupt set");

    a_exec_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_state == ST_EXEC)
        else $error("accepted beat not executed");
`endif

endmodule

### rtl/ctr_typeahead.sv
// ----------------------------------------------------------------------------
// ctr_typeahead
// Typeahead queue: circular buffer in a synchronous-read memory.
// ----------------------------------------------------------------------------
module ctr_typeahead import ctr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_ta_cmd  i_cmd,
    output t_ta_stat o_stat
);

    logic [ENTRY_W-1:0] r_mem [TYPEAHEAD_DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [PTR_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [PTR_W-1:0]   wr_addr;
    logic [PTR_W-1:0]   base_tail;
    logic [CNT_W-1:0]   base_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(TYPEAHEAD_DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    // a clear that comes with a put takes effect first
    assign base_tail  = i_cmd.clear ? '0 : r_tail;
    assign base_count = i_cmd.clear ? '0 : r_count;
    assign wr_addr    = base_tail;

    always_comb begin
        n_head  = i_cmd.clear ? '0 : r_head;
        n_tail  = base_tail;
        n_count = base_count;
        if (i_cmd.put) begin
            n_tail  = ptr_inc(base_tail);
            n_count = base_count + CNT_W'(1);
        end else if (i_cmd.get) begin
            n_head  = ptr_inc(r_head);
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            r_mem[wr_addr] <= i_cmd.put_data;
        end
        if (i_cmd.rd_req) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    assign o_stat.empty   = (r_count == '0);
    assign o_stat.full    = (r_count == CNT_W'(TYPEAHEAD_DEPTH));
    assign o_stat.rd_data = r_rd_data;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TYPEAHEAD_DEPTH))
        else $error("typeahead count beyond depth");

    a_put_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.put && !i_cmd.clear |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("typeahead put did not grow the count");

    a_get_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.get |-> r_count != '0)
        else $error("typeahead get on empty queue");
`endif

endmodule
